[rtl/bpfm_pkg.sv]
// Package for the buffer pool frame manager: op codes, status codes, states.
// No dependencies.
`timescale 1ns / 1ps
package bpfm_pkg;
   localparam logic [1:0] OP_GET = 2'd0;
   localparam logic [1:0] OP_UNPIN = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_FLUSH_ALL = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NOT_RESIDENT = 3'd1;
   localparam logic [2:0] ST_UNPINNED = 3'd2;
   localparam logic [2:0] ST_ALL_PINNED = 3'd3;
   localparam logic [2:0] ST_PIN_OVERFLOW = 3'd4;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LOOKUP = 9'b000000010,
      S_DECIDE = 9'b000000100,
      S_QFIND  = 9'b000001000,
      S_QSHIFT = 9'b000010000,
      S_VICTIM = 9'b000100000,
      S_FINISH = 9'b001000000,
      S_FLUSH  = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   // what to do once a queue removal completes
   typedef enum logic [2:0] {
      N_NONE   = 3'b001,
      N_PUSH   = 3'b010,
      N_LOAD   = 3'b100
   } next_type;
endpackage

[rtl/buffer_pool_frame_manager_unit.sv]
// Buffer pool frame manager, top level; one item at a time.
// A get, unpin or flush result passes lookup and decide, then where needed a queue or
// victim walk and finish, before it is offered on the result port.
// Flush all scans every frame, one result per dirty frame (a single result if none is dirty), stalls on rsp_ready.
// req_ready stays low until the last result transfers.
// Reset: synchronous, active high; clears valid and dirty marks, pins, queue length; sets free count to FRAMES.
`timescale 1ns / 1ps
module buffer_pool_frame_manager_unit #(
   parameter int FRAMES = 16,
   parameter int PIN_BITS = 8,
   parameter int PAGE_ID_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_page_number,
   input  logic        req_mark_dirty,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_frame_index,
   output logic        rsp_hit,
   output logic        rsp_load_request,
   output logic        rsp_writeback,
   output logic [31:0] rsp_writeback_page,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW = $clog2(FRAMES + 1);
   localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

   bpfm_pkg::state_type state_ff, state_in;
   bpfm_pkg::next_type  next_ff, next_in;

   // frame table and queue memories
   logic [PAGE_ID_BITS-1:0] page_mem [FRAMES];
   logic [IW-1:0]           queue_mem [FRAMES];
   logic [FRAMES-1:0]       valid_ff, valid_in, dirty_ff, dirty_in;
   logic [PIN_BITS-1:0]     pins_ff [FRAMES];
   logic [PIN_BITS-1:0]     pins_in [FRAMES];
   logic [CW-1:0]           qlen_ff, qlen_in, free_ff, free_in;
   logic                    policy_ff, policy_in;

   // item registers
   logic [1:0]              op_ff, op_in;
   logic [PAGE_ID_BITS-1:0] pg_ff, pg_in;
   logic                    mark_ff, mark_in;
   logic [CW-1:0]           cnt_ff, cnt_in;       // walk counter
   logic [IW-1:0]           frm_ff, frm_in;       // frame concerned
   logic                    found_ff, found_in;
   logic                    any_ff, any_in;       // flush all emitted something
   // one shared index, from the walk counter, addresses the memory reads of every walk
   logic [IW-1:0]           idx;
   logic                    page_eq, q_eq;
   logic [PAGE_ID_BITS-1:0] rd_page;
   logic [IW-1:0]           rd_q, rd_q1;

   // result register
   logic        ov_ff, ov_in;
   logic [3:0]  o_frm_ff, o_frm_in;
   logic        o_hit_ff, o_hit_in, o_load_ff, o_load_in, o_wb_ff, o_wb_in;
   logic [31:0] o_wbp_ff, o_wbp_in;
   logic [2:0]  o_st_ff, o_st_in;
   logic        o_last_ff, o_last_in;

   // memory write controls
   logic                    pw_en, qw_en;
   logic [IW-1:0]           pw_a, qw_a;
   logic [PAGE_ID_BITS-1:0] pw_d;
   logic [IW-1:0]           qw_d;

   assign idx = cnt_ff[IW-1:0];
   assign rd_page = page_mem[idx];
   assign rd_q = queue_mem[idx];
   assign rd_q1 = (cnt_ff + CW'(1) < CW'(FRAMES)) ? queue_mem[IW'(cnt_ff + CW'(1))] : rd_q;
   assign page_eq = valid_ff[idx] && (rd_page == pg_ff);
   assign q_eq = (rd_q == frm_ff);

   assign req_ready = (state_ff == bpfm_pkg::S_IDLE) && !ov_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = ov_ff;
   assign rsp_frame_index = o_frm_ff;
   assign rsp_hit = o_hit_ff;
   assign rsp_load_request = o_load_ff;
   assign rsp_writeback = o_wb_ff;
   assign rsp_writeback_page = o_wbp_ff;
   assign rsp_status = o_st_ff;
   assign rsp_last = o_last_ff;

   always_comb begin
      state_in = state_ff; next_in = next_ff;
      valid_in = valid_ff; dirty_in = dirty_ff; pins_in = pins_ff;
      qlen_in = qlen_ff; free_in = free_ff;
      policy_in = (csr_valid) ? csr_data : policy_ff;
      op_in = op_ff; pg_in = pg_ff; mark_in = mark_ff;
      cnt_in = cnt_ff; frm_in = frm_ff; found_in = found_ff; any_in = any_ff;
      ov_in = ov_ff && !rsp_ready;
      o_frm_in = o_frm_ff; o_hit_in = o_hit_ff; o_load_in = o_load_ff;
      o_wb_in = o_wb_ff; o_wbp_in = o_wbp_ff; o_st_in = o_st_ff; o_last_in = o_last_ff;
      pw_en = 1'b0; pw_a = frm_ff; pw_d = pg_ff;
      qw_en = 1'b0; qw_a = idx; qw_d = rd_q1;
      unique case (state_ff)
         bpfm_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_op; pg_in = req_page_number[PAGE_ID_BITS-1:0];
               mark_in = req_mark_dirty; cnt_in = '0; found_in = 1'b0; any_in = 1'b0;
               o_hit_in = 1'b0; o_load_in = 1'b0; o_wb_in = 1'b0; o_wbp_in = '0;
               o_st_in = bpfm_pkg::ST_OK; o_last_in = 1'b1; o_frm_in = '0;
               state_in = (req_op == bpfm_pkg::OP_FLUSH_ALL) ? bpfm_pkg::S_FLUSH
                                                             : bpfm_pkg::S_LOOKUP;
            end
         end
         bpfm_pkg::S_LOOKUP: begin
            if (page_eq) begin
               found_in = 1'b1; frm_in = idx; state_in = bpfm_pkg::S_DECIDE;
            end else if (cnt_ff == CW'(FRAMES - 1)) begin
               state_in = bpfm_pkg::S_DECIDE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         bpfm_pkg::S_DECIDE: begin
            cnt_in = '0; next_in = bpfm_pkg::N_NONE;
            o_frm_in = 4'(frm_ff);
            state_in = bpfm_pkg::S_OUT;
            priority case (op_ff)
               bpfm_pkg::OP_GET: begin
                  if (found_ff) begin
                     o_hit_in = 1'b1;
                     if (pins_ff[frm_ff] == PIN_MAX) begin
                        o_st_in = bpfm_pkg::ST_PIN_OVERFLOW;
                     end else begin
                        pins_in[frm_ff] = pins_ff[frm_ff] + PIN_BITS'(1);
                        if (policy_ff) state_in = bpfm_pkg::S_QFIND;
                     end
                  end else if (free_ff != '0) begin
                     free_in = free_ff - CW'(1);
                     frm_in = IW'(free_ff - CW'(1));
                     next_in = bpfm_pkg::N_LOAD;
                     state_in = bpfm_pkg::S_QFIND;
                  end else begin
                     state_in = bpfm_pkg::S_VICTIM;
                  end
               end
               bpfm_pkg::OP_UNPIN: begin
                  if (!found_ff) begin
                     o_st_in = bpfm_pkg::ST_NOT_RESIDENT; o_frm_in = '0;
                  end else if (pins_ff[frm_ff] == '0) begin
                     o_st_in = bpfm_pkg::ST_UNPINNED;
                  end else begin
                     pins_in[frm_ff] = pins_ff[frm_ff] - PIN_BITS'(1);
                     if (mark_ff) dirty_in[frm_ff] = 1'b1;
                     if (pins_ff[frm_ff] == PIN_BITS'(1)) begin
                        next_in = bpfm_pkg::N_PUSH;
                        state_in = bpfm_pkg::S_QFIND;
                     end
                  end
               end
               default: begin
                  if (!found_ff) begin
                     o_st_in = bpfm_pkg::ST_NOT_RESIDENT; o_frm_in = '0;
                  end else if (dirty_ff[frm_ff]) begin
                     o_wb_in = 1'b1; o_wbp_in = 32'(page_mem[frm_ff]);
                     dirty_in[frm_ff] = 1'b0;
                  end
               end
            endcase
            if (state_in == bpfm_pkg::S_OUT) ov_in = 1'b1;
         end
         bpfm_pkg::S_VICTIM: begin
            if (cnt_ff >= qlen_ff) begin
               o_st_in = bpfm_pkg::ST_ALL_PINNED; o_frm_in = '0;
               ov_in = 1'b1; state_in = bpfm_pkg::S_OUT;
            end else if (pins_ff[rd_q] == '0) begin
               frm_in = rd_q; next_in = bpfm_pkg::N_LOAD;
               state_in = bpfm_pkg::S_QSHIFT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         bpfm_pkg::S_QFIND: begin
            if (cnt_ff >= qlen_ff) begin
               // not queued
               if (next_ff == bpfm_pkg::N_PUSH) begin
                  qw_en = (qlen_ff < CW'(FRAMES)); qw_a = IW'(qlen_ff); qw_d = frm_ff;
                  if (qlen_ff < CW'(FRAMES)) qlen_in = qlen_ff + CW'(1);
               end
               state_in = bpfm_pkg::S_FINISH;
            end else if (q_eq) begin
               if (next_ff == bpfm_pkg::N_PUSH && !policy_ff) state_in = bpfm_pkg::S_FINISH;
               else state_in = bpfm_pkg::S_QSHIFT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         bpfm_pkg::S_QSHIFT: begin
            if (cnt_ff + CW'(1) >= qlen_ff) begin
               qlen_in = qlen_ff - CW'(1);
               if (next_ff == bpfm_pkg::N_PUSH) begin
                  qw_en = 1'b1; qw_a = IW'(qlen_ff - CW'(1)); qw_d = frm_ff;
                  qlen_in = qlen_ff;
               end
               state_in = bpfm_pkg::S_FINISH;
            end else begin
               qw_en = 1'b1; qw_a = idx; qw_d = rd_q1;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         bpfm_pkg::S_FINISH: begin
            o_frm_in = 4'(frm_ff);
            if (next_ff == bpfm_pkg::N_LOAD) begin
               if (valid_ff[frm_ff] && dirty_ff[frm_ff]) begin
                  o_wb_in = 1'b1; o_wbp_in = 32'(page_mem[frm_ff]);
               end
               pw_en = 1'b1;
               valid_in[frm_ff] = 1'b1; dirty_in[frm_ff] = 1'b0;
               pins_in[frm_ff] = PIN_BITS'(1);
               o_load_in = 1'b1;
               // a victim may still sit in the queue only if taken free; free
               // frames are never queued, so nothing more to remove
            end
            ov_in = 1'b1; state_in = bpfm_pkg::S_OUT;
         end
         bpfm_pkg::S_FLUSH: begin
            if (!ov_ff || rsp_ready) begin
               if (cnt_ff == CW'(FRAMES)) begin
                  if (!any_ff) begin
                     o_frm_in = '0; o_wb_in = 1'b0; o_wbp_in = '0;
                     o_last_in = 1'b1; ov_in = 1'b1;
                  end
                  state_in = bpfm_pkg::S_OUT;
               end else if (valid_ff[idx] && dirty_ff[idx]) begin
                  dirty_in[idx] = 1'b0;
                  o_frm_in = 4'(idx); o_wb_in = 1'b1; o_wbp_in = 32'(rd_page);
                  o_last_in = ((valid_ff & dirty_ff) >> cnt_ff) == FRAMES'(1);
                  ov_in = 1'b1; any_in = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         bpfm_pkg::S_OUT: begin
            if (!ov_ff || rsp_ready) state_in = bpfm_pkg::S_IDLE;
         end
         default: state_in = bpfm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pw_en) page_mem[pw_a] <= pw_d;
      if (qw_en) queue_mem[qw_a] <= qw_d;
      op_ff <= op_in; pg_ff <= pg_in; mark_ff <= mark_in; cnt_ff <= cnt_in;
      frm_ff <= frm_in; found_ff <= found_in; any_ff <= any_in;
      o_frm_ff <= o_frm_in; o_hit_ff <= o_hit_in; o_load_ff <= o_load_in;
      o_wb_ff <= o_wb_in; o_wbp_ff <= o_wbp_in; o_st_ff <= o_st_in; o_last_ff <= o_last_in;
      if (reset) begin
         state_ff <= bpfm_pkg::S_IDLE; next_ff <= bpfm_pkg::N_NONE;
         valid_ff <= '0; dirty_ff <= '0; qlen_ff <= '0; free_ff <= CW'(FRAMES);
         policy_ff <= 1'b1; ov_ff <= 1'b0;
         for (int i = 0; i < FRAMES; i++) pins_ff[i] <= '0;
      end else begin
         state_ff <= state_in; next_ff <= next_in;
         valid_ff <= valid_in; dirty_ff <= dirty_in; qlen_ff <= qlen_in; free_ff <= free_in;
         policy_ff <= policy_in; ov_ff <= ov_in; pins_ff <= pins_in;
      end
   end
endmodule
